/* rtl/ffbp_pkg.sv */
// Shared types and constants for the first-fit bin packer.
package ffbp_pkg;

  localparam int unsigned WeightW   = 16;
  localparam int unsigned BinIdxW   = 6;
  localparam int unsigned BinsUsedW = 7;
  localparam int unsigned StatusW   = 2;

  localparam logic [WeightW-1:0] CapReset = 16'd150;

  localparam logic [StatusW-1:0] STAT_PLACED = 2'd0;
  localparam logic [StatusW-1:0] STAT_HEAVY  = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic               new_problem;
    logic [WeightW-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [BinIdxW-1:0]   bin_index;
    logic [BinsUsedW-1:0] bins_used;
    logic [StatusW-1:0]   status;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input word, start a scan
    logic step;    // scan advances this cycle
    logic issue;   // read the next open bin
    logic finish;  // place the weight and load the result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;      // open bins left to read
    logic pending;   // read data of one bin is present
    logic hit;       // that bin has room
    logic out_busy;  // result register full and stalled
  } dp_stat_t;

endpackage

/* rtl/first_fit_bin_packer.sv */
// A word is accepted while idle; the scan reads the open bins in order, one read of
// the bin space memory per cycle unless a stalled result holds it, and ends at the
// first bin with room or after the last open bin; the result is valid the cycle after.
// The next word is taken while a result still waits in the output register.
// Reset: capacity 150, bin 0 open at that capacity; the bin memory itself is not cleared.
module first_fit_bin_packer import ffbp_pkg::*; #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [WeightW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  ffbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffbp_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a new word starts a scan, so the input is busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled during scan");

  // a finished word never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten");

  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished word gave no result");

  // a scan only ends while the input side is busy
  a_finish_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> in_stall_o)
    else $error("scan finished outside of scan state");

endmodule

/* rtl/ffbp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module ffbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/ffbp_ctrl.sv */
// Scan controller: accepts a word, steps the bin scan, ends it on a hit or a miss.
module ffbp_ctrl import ffbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   go;
  logic   done;

  assign go   = !stat_i.out_busy;
  assign done = go && stat_i.pending && (stat_i.hit || !stat_i.more);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.step   = go;
        cmd_o.issue  = go && stat_i.more;
        cmd_o.finish = done;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ffbp_dp.sv */
// Datapath: capacity register, bin space memory, open count, compare and result register.
module ffbp_dp import ffbp_pkg::*; #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [WeightW-1:0] cfg_data_i,
  input  in_item_t           in_data_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_BINS);
  localparam int unsigned CntW = $clog2(MAX_BINS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BINS);

  logic [WeightW-1:0] cap_q;
  logic [WeightW-1:0] weight_q;
  logic [CntW-1:0]    open_q, open_d;
  logic [CntW-1:0]    rd_addr_q;
  logic [IdxW-1:0]    pend_idx_q;
  logic               pending_q;
  // bin 0 holds the capacity seen at the last clear until it is first written
  logic               fresh_q;
  logic [WeightW-1:0] bin0_cap_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [WeightW-1:0] rd_data;
  logic [WeightW-1:0] space_cur;
  logic               hit;
  logic               more;
  logic               wr_en;
  logic [IdxW-1:0]    wr_idx;
  logic [WeightW-1:0] wr_data;
  logic [IdxW-1:0]    res_idx;
  logic [StatusW-1:0] res_status;

  ffbp_ram #(
    .WIDTH (WeightW),
    .DEPTH (MAX_BINS)
  ) u_space (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.issue),
    .rd_addr_i (rd_addr_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  assign space_cur = (fresh_q && (pend_idx_q == '0)) ? bin0_cap_q : rd_data;
  assign hit       = (weight_q <= space_cur);
  assign more      = (rd_addr_q < open_q);

  assign stat_o.more     = more;
  assign stat_o.pending  = pending_q;
  assign stat_o.hit      = hit;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  // placement decision
  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = pend_idx_q;
    wr_data    = space_cur - weight_q;
    open_d     = open_q;
    res_idx    = '0;
    res_status = STAT_FULL;
    if (cmd_i.finish) begin
      if (hit) begin
        wr_en      = 1'b1;
        res_idx    = pend_idx_q;
        res_status = STAT_PLACED;
      end else if (open_q < MaxCnt) begin
        wr_en   = 1'b1;
        wr_idx  = open_q[IdxW-1:0];
        res_idx = open_q[IdxW-1:0];
        open_d  = open_q + CntW'(1);
        if (weight_q <= cap_q) begin
          wr_data    = cap_q - weight_q;
          res_status = STAT_PLACED;
        end else begin
          wr_data    = '0;
          res_status = STAT_HEAVY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      open_q      <= CntW'(1);
      fresh_q     <= 1'b1;
      bin0_cap_q  <= CapReset;
      pending_q   <= 1'b0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        rd_addr_q <= '0;
        pending_q <= 1'b0;
        if (in_data_i.new_problem) begin
          open_q     <= CntW'(1);
          fresh_q    <= 1'b1;
          bin0_cap_q <= cap_q;
        end
      end else if (cmd_i.step) begin
        pending_q <= cmd_i.issue;
        if (cmd_i.issue) begin
          rd_addr_q <= rd_addr_q + CntW'(1);
        end
      end
      if (cmd_i.finish) begin
        open_q <= open_d;
        if (hit && (pend_idx_q == '0)) begin
          fresh_q <= 1'b0;
        end
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      weight_q <= in_data_i.weight;
    end
    if (cmd_i.issue) begin
      pend_idx_q <= rd_addr_q[IdxW-1:0];
    end
    if (cmd_i.finish) begin
      out_q.bin_index <= BinIdxW'(res_idx);
      out_q.bins_used <= BinsUsedW'(open_d);
      out_q.status    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
